### hdl/pi_controller_antiwindup_defines.svh
// Assertion shorthands shared by the controller modules.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef PI_CONTROLLER_ANTIWINDUP_DEFINES_SVH
`define PI_CONTROLLER_ANTIWINDUP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PICA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PICA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pica_pkg.sv
`timescale 1ns / 1ps

package pica_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int DATA_W = 32;
    localparam int GAIN_W = 24;
    localparam int LIM_W  = 31;
    localparam int PROD_W = GAIN_W + 1 + DATA_W;
    localparam int SUM_W  = PROD_W + 3;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_INTEG_GAIN   = 3'd1,
        REG_OUTPUT_UPPER = 3'd2,
        REG_OUTPUT_LOWER = 3'd3,
        REG_ACCUM_LIMIT  = 3'd4,
        REG_WINDUP_MODE  = 3'd5
    } cfg_reg_t;

    localparam logic [GAIN_W-1:0]        PROP_GAIN_RST    = 24'd13107;
    localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST   = 24'd3277;
    localparam logic signed [DATA_W-1:0] OUTPUT_UPPER_RST = 32'sd65536;
    localparam logic signed [DATA_W-1:0] OUTPUT_LOWER_RST = -32'sd65536;
    localparam logic [LIM_W-1:0]         ACCUM_LIMIT_RST  = 31'd1310720;
    localparam logic                     WINDUP_MODE_RST  = 1'b1;

    typedef struct packed {
        logic [GAIN_W-1:0]        prop_gain;
        logic [GAIN_W-1:0]        integ_gain;
        logic signed [DATA_W-1:0] output_upper;
        logic signed [DATA_W-1:0] output_lower;
        logic [LIM_W-1:0]         accum_limit;
        logic                     windup_mode;
    } cfg_t;

    // Error and both error products, ready for the integrator stage.
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] err;
        logic signed [PROD_W-1:0] p_term;
        logic signed [PROD_W-1:0] ki_err;
    } front_t;

    // Terms of the output sum after the integrator has been updated.
    typedef struct packed {
        logic                     valid;
        logic signed [PROD_W-1:0] p_term;
        logic signed [PROD_W-1:0] ki_acc;
        logic                     take;
    } loop_t;

endpackage

### hdl/pica_front.sv
`timescale 1ns / 1ps

module pica_front
    import pica_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [DATA_W-1:0] setpoint,
    input  logic signed [DATA_W-1:0] measured,
    input  logic [GAIN_W-1:0]        prop_gain,
    input  logic [GAIN_W-1:0]        integ_gain,
    output front_t                   front
);

    logic                     s0_valid_reg;
    logic signed [DATA_W-1:0] setpoint_reg;
    logic signed [DATA_W-1:0] measured_reg;
    logic                     s1_valid_reg;
    logic signed [DATA_W-1:0] err_reg;
    logic signed [DATA_W-1:0] err_next;
    logic signed [DATA_W:0]   diff;
    logic signed [PROD_W-1:0] p_next;
    logic signed [PROD_W-1:0] ki_err_next;
    front_t                   front_reg;

    always_comb
    begin
        diff = (DATA_W+1)'(setpoint_reg) - (DATA_W+1)'(measured_reg);
        if (diff[DATA_W] != diff[DATA_W-1])
        begin
            err_next = diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            err_next = diff[DATA_W-1:0];
        end
        p_next      = $signed({1'b0, prop_gain}) * err_reg;
        ki_err_next = $signed({1'b0, integ_gain}) * err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            front_reg    <= '0;
        end
        else if (en)
        begin
            s0_valid_reg     <= in_valid;
            s1_valid_reg     <= s0_valid_reg;
            front_reg.valid  <= s1_valid_reg;
            front_reg.err    <= err_reg;
            front_reg.p_term <= p_next;
            front_reg.ki_err <= ki_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            setpoint_reg <= setpoint;
            measured_reg <= measured;
            err_reg      <= err_next;
        end
    end

    assign front = front_reg;

endmodule

### hdl/pica_integ.sv
`timescale 1ns / 1ps
`include "pi_controller_antiwindup_defines.svh"

module pica_integ
    import pica_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     cfg_we,
    input  front_t                   front,
    input  logic [GAIN_W-1:0]        integ_gain,
    input  logic signed [DATA_W-1:0] output_upper,
    input  logic signed [DATA_W-1:0] output_lower,
    input  logic [LIM_W-1:0]         accum_limit,
    input  logic                     windup_mode,
    output loop_t                    loop
);

    // ki_acc_reg tracks integ_gain * acc_reg. After a register write it is
    // rebuilt from a separately registered product; beats are not held off.
    logic signed [DATA_W-1:0] acc_reg;
    logic signed [DATA_W-1:0] acc_next;
    logic signed [PROD_W-1:0] ki_acc_reg;
    logic signed [PROD_W-1:0] ki_acc_next;
    logic signed [PROD_W-1:0] calc_reg;
    logic signed [PROD_W-1:0] ki_lim_reg;
    logic [1:0]               sync_cnt_reg;
    loop_t                    loop_reg;

    logic signed [SUM_W-1:0]  pred_sum;
    logic signed [SUM_W-1:0]  pred;
    logic signed [SUM_W-1:0]  upper_ext;
    logic signed [SUM_W-1:0]  lower_ext;
    logic signed [DATA_W:0]   acc_sum;
    logic signed [DATA_W:0]   lim_ext;
    logic signed [DATA_W:0]   neg_lim;
    logic                     take;

    always_comb
    begin
        upper_ext = SUM_W'(output_upper);
        lower_ext = SUM_W'(output_lower);
        pred_sum  = SUM_W'(front.p_term) + SUM_W'(ki_acc_reg) + SUM_W'(front.ki_err);
        pred      = pred_sum >>> FRAC_BITS;
        take      = !windup_mode || ((pred <= upper_ext) && (pred >= lower_ext));

        lim_ext = $signed({2'b00, accum_limit});
        neg_lim = -lim_ext;
        acc_sum = (DATA_W+1)'(acc_reg) + (DATA_W+1)'(front.err);
        if (acc_sum > lim_ext)
        begin
            acc_next    = lim_ext[DATA_W-1:0];
            ki_acc_next = ki_lim_reg;
        end
        else if (acc_sum < neg_lim)
        begin
            acc_next    = neg_lim[DATA_W-1:0];
            ki_acc_next = -ki_lim_reg;
        end
        else
        begin
            acc_next    = acc_sum[DATA_W-1:0];
            ki_acc_next = ki_acc_reg + front.ki_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            ki_acc_reg   <= '0;
            sync_cnt_reg <= 2'd0;
            loop_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                sync_cnt_reg <= 2'd2;
            end
            else if (sync_cnt_reg != 2'd0)
            begin
                sync_cnt_reg <= sync_cnt_reg - 2'd1;
            end

            if (en)
            begin
                loop_reg.valid  <= front.valid;
                loop_reg.p_term <= front.p_term;
                loop_reg.take   <= take;
                loop_reg.ki_acc <= take ? ki_acc_next : ki_acc_reg;
            end

            if (en && front.valid && take)
            begin
                acc_reg    <= acc_next;
                ki_acc_reg <= ki_acc_next;
            end
            else if (sync_cnt_reg == 2'd1)
            begin
                ki_acc_reg <= calc_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        calc_reg   <= $signed({1'b0, integ_gain}) * acc_reg;
        ki_lim_reg <= $signed({1'b0, integ_gain}) * $signed({1'b0, accum_limit});
    end

    assign loop = loop_reg;

    `PICA_ASSERT_NEXT(a_acc_within_limit, en && front.valid && take && !cfg_we,
        ((DATA_W+1)'(acc_reg) <= lim_ext) && ((DATA_W+1)'(acc_reg) >= neg_lim),
        "accumulator outside its limit after integrating")
    `PICA_ASSERT_NEXT(a_acc_held, en && front.valid && !take, $stable(acc_reg),
        "accumulator changed on a beat that did not integrate")

endmodule

### hdl/pica_out.sv
`timescale 1ns / 1ps
`include "pi_controller_antiwindup_defines.svh"

module pica_out
    import pica_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  loop_t                    loop,
    input  logic signed [DATA_W-1:0] output_upper,
    input  logic signed [DATA_W-1:0] output_lower,
    input  logic                     out_ready,
    output logic                     en,
    output logic                     out_valid,
    output logic signed [DATA_W-1:0] drive,
    output logic                     integrated
);

    logic signed [SUM_W-1:0]  y_sum;
    logic signed [SUM_W-1:0]  y;
    logic signed [SUM_W-1:0]  upper_ext;
    logic signed [SUM_W-1:0]  lower_ext;
    logic signed [DATA_W-1:0] drive_w;
    logic                     push;
    logic                     pop;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] drive_reg;
    logic                     integrated_reg;
    logic                     skid_valid_reg;
    logic signed [DATA_W-1:0] skid_drive_reg;
    logic                     skid_integrated_reg;

    always_comb
    begin
        upper_ext = SUM_W'(output_upper);
        lower_ext = SUM_W'(output_lower);
        y_sum     = SUM_W'(loop.p_term) + SUM_W'(loop.ki_acc);
        y         = y_sum >>> FRAC_BITS;
        if (y > upper_ext)
        begin
            drive_w = output_upper;
        end
        else if (y < lower_ext)
        begin
            drive_w = output_lower;
        end
        else
        begin
            drive_w = y[DATA_W-1:0];
        end
    end

    assign en   = !skid_valid_reg;
    assign push = en && loop.valid;
    assign pop  = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                drive_reg      <= skid_drive_reg;
                integrated_reg <= skid_integrated_reg;
            end
            else
            begin
                drive_reg      <= drive_w;
                integrated_reg <= loop.take;
            end
        end
        else if (push)
        begin
            skid_drive_reg      <= drive_w;
            skid_integrated_reg <= loop.take;
        end
    end

    assign out_valid  = out_valid_reg;
    assign drive      = drive_reg;
    assign integrated = integrated_reg;

    `PICA_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid entry held without a pending output beat")
    `PICA_ASSERT_NOW(a_drive_in_range, push && (output_lower <= output_upper),
        (drive_w <= output_upper) && (drive_w >= output_lower),
        "drive outside the output limits")

endmodule

### hdl/pi_controller_antiwindup.sv
// PI controller with conditional-integration anti-windup in signed fixed point
// with FRAC_BITS fraction bits. Each input beat carries a setpoint and a
// measurement; each yields exactly one output beat with the clamped drive and a
// flag telling whether the integrator took the error. The block takes one beat
// per clock while s_tready is high: the integrator update closes within a single
// pipeline stage, so consecutive beats need no spacing. A result passes the input,
// error, product, integrator and output registers. A two-entry output register
// with a skid entry decouples both sides, so s_tready does not depend on m_tready
// combinationally. Register writes are allowed only while no beat is in flight
// and apply to all later beats; after a write the stored integral product is rebuilt
// from a registered product before any newly accepted beat reaches the integrator.
`timescale 1ns / 1ps

module pi_controller_antiwindup
    import pica_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,    // setpoint [31:0], measured [63:32]

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,    // drive [31:0], integrated [32], zero fill

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata
);

    cfg_t                     cfg_reg;
    logic                     en;
    front_t                   front;
    loop_t                    loop;
    logic signed [DATA_W-1:0] drive;
    logic                     integrated;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain    <= PROP_GAIN_RST;
            cfg_reg.integ_gain   <= INTEG_GAIN_RST;
            cfg_reg.output_upper <= OUTPUT_UPPER_RST;
            cfg_reg.output_lower <= OUTPUT_LOWER_RST;
            cfg_reg.accum_limit  <= ACCUM_LIMIT_RST;
            cfg_reg.windup_mode  <= WINDUP_MODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PROP_GAIN:    cfg_reg.prop_gain    <= cfg_wdata[GAIN_W-1:0];
                REG_INTEG_GAIN:   cfg_reg.integ_gain   <= cfg_wdata[GAIN_W-1:0];
                REG_OUTPUT_UPPER: cfg_reg.output_upper <= cfg_wdata;
                REG_OUTPUT_LOWER: cfg_reg.output_lower <= cfg_wdata;
                REG_ACCUM_LIMIT:  cfg_reg.accum_limit  <= cfg_wdata[LIM_W-1:0];
                REG_WINDUP_MODE:  cfg_reg.windup_mode  <= cfg_wdata[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign s_tready = en;

    pica_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid),
        .setpoint   (s_tdata[31:0]),
        .measured   (s_tdata[63:32]),
        .prop_gain  (cfg_reg.prop_gain),
        .integ_gain (cfg_reg.integ_gain),
        .front      (front)
    );

    pica_integ #(
        .FRAC_BITS (FRAC_BITS)
    ) u_integ (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .cfg_we       (cfg_we),
        .front        (front),
        .integ_gain   (cfg_reg.integ_gain),
        .output_upper (cfg_reg.output_upper),
        .output_lower (cfg_reg.output_lower),
        .accum_limit  (cfg_reg.accum_limit),
        .windup_mode  (cfg_reg.windup_mode),
        .loop         (loop)
    );

    pica_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .loop         (loop),
        .output_upper (cfg_reg.output_upper),
        .output_lower (cfg_reg.output_lower),
        .out_ready    (m_tready),
        .en           (en),
        .out_valid    (m_tvalid),
        .drive        (drive),
        .integrated   (integrated)
    );

    assign m_tdata = {7'b0, integrated, drive};

endmodule

### verif/pi_controller_antiwindup_tb.sv
`timescale 1ns / 1ps

module pi_controller_antiwindup_tb;
    import pica_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int PHASES = 12;
    localparam int PHASE_BEATS = 90;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_SHOWN = 10;
    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
    localparam logic signed [31:0] ONE = 32'sd65536;
    localparam longint SAT_HI = 64'sh7FFF_FFFF;
    localparam longint SAT_LO = -64'sh8000_0000;

    typedef struct {
        logic signed [31:0] drive;
        logic               took;
    } control_out_t;

    typedef struct {
        bit                 is_cfg;
        cfg_reg_t           sel;
        logic [31:0]        value;
        logic signed [31:0] setpoint;
        logic signed [31:0] measured;
        bit                 fixed;
        logic signed [31:0] fixed_drive;
        logic               fixed_took;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [39:0]          m_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_wdata = '0;

    // Typed-in expectation that travels with the beat on the input bus.
    bit                 row_fixed = 1'b0;
    logic signed [31:0] row_drive = '0;
    logic               row_take = 1'b0;

    // Controller shadow state, starting from the reset values.
    logic [GAIN_W-1:0]        kp_reg = PROP_GAIN_RST;
    logic [GAIN_W-1:0]        ki_reg = INTEG_GAIN_RST;
    logic signed [DATA_W-1:0] out_hi = OUTPUT_UPPER_RST;
    logic signed [DATA_W-1:0] out_lo = OUTPUT_LOWER_RST;
    logic [LIM_W-1:0]         integ_limit = ACCUM_LIMIT_RST;
    logic                     cond_mode = WINDUP_MODE_RST;
    longint                   integral = 0;

    control_out_t pending_outputs[$];
    stim_row_t    directed_rows[$];
    int beats_sent = 0;
    int results_seen = 0;
    int fault_count = 0;
    int stall_left = 0;
    bit rx_steady = 1'b0;

    pi_controller_antiwindup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'h00FF_FFFF;
            2, 3: return $urandom();
            default: return $urandom_range(0, 1 << 17);
        endcase
    endfunction

    function automatic logic signed [31:0] extreme_value();
        case ($urandom_range(0, 3))
            0: return MAX32;
            1: return MIN32;
            2: return 32'sd0;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_SHOWN)
        begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    function automatic void set_shadow_reg(input cfg_reg_t sel, input logic [31:0] v);
        case (sel)
            REG_PROP_GAIN:    kp_reg = v[GAIN_W-1:0];
            REG_INTEG_GAIN:   ki_reg = v[GAIN_W-1:0];
            REG_OUTPUT_UPPER: out_hi = v;
            REG_OUTPUT_LOWER: out_lo = v;
            REG_ACCUM_LIMIT:  integ_limit = v[LIM_W-1:0];
            REG_WINDUP_MODE:  cond_mode = v[0];
            default: ;
        endcase
    endfunction

    // One control step: saturated error, optional conditional integration,
    // then the full-width output floored back to FRAC fraction bits and clamped.
    function automatic control_out_t pi_step(input logic signed [31:0] sp,
                                             input logic signed [31:0] ms);
        control_out_t res;
        longint diff;
        longint kp;
        longint ki;
        longint p_term;
        longint pred;
        longint lim;
        longint y;
        diff = longint'(sp) - longint'(ms);
        if (diff > SAT_HI)
        begin
            diff = SAT_HI;
        end
        else if (diff < SAT_LO)
        begin
            diff = SAT_LO;
        end
        kp = longint'(kp_reg);
        ki = longint'(ki_reg);
        p_term = kp * diff;
        res.took = 1'b1;
        if (cond_mode)
        begin
            pred = (p_term + ki * (integral + diff)) >>> FRAC;
            res.took = (pred <= longint'(out_hi)) && (pred >= longint'(out_lo));
        end
        if (res.took)
        begin
            lim = longint'(integ_limit);
            integral = integral + diff;
            if (integral > lim)
            begin
                integral = lim;
            end
            else if (integral < -lim)
            begin
                integral = -lim;
            end
        end
        y = (p_term + ki * integral) >>> FRAC;
        if (y > longint'(out_hi))
        begin
            y = longint'(out_hi);
        end
        else if (y < longint'(out_lo))
        begin
            y = longint'(out_lo);
        end
        res.drive = y[31:0];
        return res;
    endfunction

    task automatic add_beat(input logic signed [31:0] sp, input logic signed [31:0] ms);
        stim_row_t row;
        row = '{sel: REG_PROP_GAIN, default: '0};
        row.setpoint = sp;
        row.measured = ms;
        directed_rows.push_back(row);
    endtask

    task automatic add_fixed(input logic signed [31:0] sp, input logic signed [31:0] ms,
                             input logic signed [31:0] drive, input logic took);
        stim_row_t row;
        row = '{sel: REG_PROP_GAIN, default: '0};
        row.setpoint = sp;
        row.measured = ms;
        row.fixed = 1'b1;
        row.fixed_drive = drive;
        row.fixed_took = took;
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg(input cfg_reg_t sel, input logic [31:0] v);
        stim_row_t row;
        row = '{sel: REG_PROP_GAIN, default: '0};
        row.is_cfg = 1'b1;
        row.sel = sel;
        row.value = v;
        directed_rows.push_back(row);
    endtask

    task automatic send_beat(input logic signed [31:0] sp, input logic signed [31:0] ms,
                             input bit fixed, input logic signed [31:0] drive,
                             input logic took, input bit burst);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {ms, sp};
        row_fixed <= fixed;
        row_drive <= drive;
        row_take  <= took;
        do @(posedge clk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (results_seen < beats_sent) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The caller lowers cfg_we once the last write of a batch has gone in.
    task automatic write_reg(input cfg_reg_t sel, input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= v;
        @(posedge clk);
        set_shadow_reg(sel, v);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!rx_steady && $urandom_range(0, 3) == 0)
        begin
            stall_left = pick_gap();
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        control_out_t want;
        control_out_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (pending_outputs.size() == 0)
                begin
                    note_fault($sformatf("output beat with nothing pending: drive %0d",
                                         $signed(m_tdata[31:0])));
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    if (m_tdata[31:0] !== want.drive)
                    begin
                        note_fault($sformatf("drive: expected %0d, got %0d",
                                             want.drive, $signed(m_tdata[31:0])));
                    end
                    if (m_tdata[32] !== want.took)
                    begin
                        note_fault($sformatf("integrated: expected %0b, got %0b",
                                             want.took, m_tdata[32]));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                got = pi_step(s_tdata[31:0], s_tdata[63:32]);
                if (row_fixed)
                begin
                    got.drive = row_drive;
                    got.took = row_take;
                end
                pending_outputs.push_back(got);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        stim_row_t row;
        logic signed [31:0] sp;
        logic signed [31:0] ms;
        logic signed [31:0] base;
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        logic [31:0] lim;
        int span;
        bit prev_cfg;
        bit burst;

        // Reset defaults: zero error, then saturated error both ways.
        add_fixed(32'sd0, 32'sd0, 32'sd0, 1'b1);
        add_fixed(MAX32, MIN32, ONE, 1'b0);
        add_fixed(MIN32, MAX32, -ONE, 1'b0);
        add_beat(ONE, 32'sd0);
        add_beat(32'sd0, ONE);
        add_beat(32'sh1234_5678, 32'shFEDC_BA98);
        // Unity proportional gain only: predictions that land on a limit count as within.
        add_cfg(REG_PROP_GAIN, ONE);
        add_cfg(REG_INTEG_GAIN, 32'd0);
        add_cfg(REG_OUTPUT_UPPER, ONE);
        add_cfg(REG_OUTPUT_LOWER, -ONE);
        add_cfg(REG_WINDUP_MODE, 32'd1);
        add_fixed(ONE, 32'sd0, ONE, 1'b1);
        add_fixed(ONE + 32'sd1, 32'sd0, ONE, 1'b0);
        add_fixed(32'sd0, ONE, -ONE, 1'b1);
        add_fixed(32'sd0, ONE + 32'sd1, -ONE, 1'b0);
        // Crossed limits: never integrates, upper limit is tested first.
        add_cfg(REG_OUTPUT_UPPER, -ONE);
        add_cfg(REG_OUTPUT_LOWER, ONE);
        add_fixed(32'sd0, 32'sd0, -ONE, 1'b0);
        add_fixed(3 * ONE, 32'sd0, -ONE, 1'b0);
        add_fixed(32'sd0, 3 * ONE, ONE, 1'b0);
        // Plain integrator with a zero clamp empties the accumulator.
        add_cfg(REG_PROP_GAIN, 32'd0);
        add_cfg(REG_INTEG_GAIN, ONE);
        add_cfg(REG_OUTPUT_UPPER, MAX32);
        add_cfg(REG_OUTPUT_LOWER, MIN32);
        add_cfg(REG_ACCUM_LIMIT, 32'd0);
        add_cfg(REG_WINDUP_MODE, 32'd0);
        add_fixed(32'sd0, 32'sd0, 32'sd0, 1'b1);
        add_cfg(REG_ACCUM_LIMIT, 32'h7FFF_FFFF);
        add_beat(5 * ONE, 32'sd0);
        add_beat(5 * ONE, 32'sd0);
        // A lowered clamp leaves the integral alone until the next addition.
        add_cfg(REG_ACCUM_LIMIT, ONE);
        add_cfg(REG_OUTPUT_UPPER, 10 * ONE);
        add_cfg(REG_WINDUP_MODE, 32'd1);
        add_beat(ONE, 32'sd0);
        add_beat(32'sd0, ONE);
        // Largest gains and clamp, written with junk above the register width.
        add_cfg(REG_PROP_GAIN, 32'hFFFF_FFFF);
        add_cfg(REG_INTEG_GAIN, 32'hFFFF_FFFF);
        add_cfg(REG_OUTPUT_UPPER, MAX32);
        add_cfg(REG_OUTPUT_LOWER, MIN32);
        add_cfg(REG_ACCUM_LIMIT, 32'hFFFF_FFFF);
        add_cfg(REG_WINDUP_MODE, 32'hFFFF_FFFE);
        add_beat(MAX32, MIN32);
        add_beat(MIN32, MAX32);
        add_beat(MIN32, MAX32);
        add_beat(-32'sd1, 32'sd0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        prev_cfg = 1'b0;
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_cfg)
            begin
                if (!prev_cfg)
                begin
                    wait_drained();
                end
                write_reg(row.sel, row.value);
            end
            else
            begin
                if (prev_cfg)
                begin
                    cfg_we <= 1'b0;
                end
                send_beat(row.setpoint, row.measured, row.fixed, row.fixed_drive,
                          row.fixed_took, 1'b0);
            end
            prev_cfg = row.is_cfg;
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            write_reg(REG_PROP_GAIN, pick_gain());
            write_reg(REG_INTEG_GAIN, pick_gain());
            case ($urandom_range(0, 9))
                0:
                begin
                    hi = MAX32;
                    lo = MIN32;
                end
                1:
                begin
                    span = $urandom_range(0, 4 << 16);
                    hi = -span;
                    lo = span;
                end
                2:
                begin
                    hi = $urandom();
                    lo = $urandom();
                end
                default:
                begin
                    hi = $urandom_range(1, 8 << 16);
                    lo = -int'($urandom_range(0, 8 << 16));
                end
            endcase
            write_reg(REG_OUTPUT_UPPER, hi);
            write_reg(REG_OUTPUT_LOWER, lo);
            case ($urandom_range(0, 9))
                0: lim = 32'd0;
                1: lim = 32'hFFFF_FFFF;
                2: lim = $urandom();
                default: lim = $urandom_range(0, 32 << 16);
            endcase
            write_reg(REG_ACCUM_LIMIT, lim);
            write_reg(REG_WINDUP_MODE, $urandom());
            cfg_we <= 1'b0;

            burst = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            base = int'($urandom_range(0, 64 << 16)) - (32 << 16);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if ((ph == 2 && n == PHASE_BEATS / 2) || $urandom_range(0, 199) == 0)
                begin
                    wait_drained();
                end
                case ($urandom_range(0, 9))
                    6, 7:
                    begin
                        sp = $urandom();
                        ms = $urandom();
                    end
                    8:
                    begin
                        sp = extreme_value();
                        ms = extreme_value();
                    end
                    9:
                    begin
                        sp = base;
                        ms = $urandom();
                    end
                    default:
                    begin
                        sp = base + int'($urandom_range(0, 2 << 16)) - ONE;
                        ms = sp - (int'($urandom_range(0, 8 << 16)) - (4 << 16));
                    end
                endcase
                send_beat(sp, ms, 1'b0, 32'sd0, 1'b0, burst);
            end
        end

        rx_steady = 1'b0;
        wait_drained();
        if (pending_outputs.size() != 0)
        begin
            note_fault($sformatf("%0d results never arrived", pending_outputs.size()));
        end
        if (fault_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
